FILE: rtl/bpx_pkg.sv
// bpx_pkg: shared types and constants for the bitmap row palette expander
// no dependencies; imported by the expander and its checker
package bpx_pkg;

  localparam int COL_W      = 13;
  localparam int POS_W      = 14;
  localparam int HELD_W     = 16;
  localparam int CNT_W      = 4;
  localparam int SUB_W      = 3;
  localparam int CFG_DATA_W = 14;
  localparam int REG_IDX_W  = 2;

  typedef enum logic [1:0] {
    MODE_1BPP  = 2'd0,
    MODE_4BPP  = 2'd1,
    MODE_8BPP  = 2'd2,
    MODE_24BPP = 2'd3
  } mode_t;

  localparam logic CMD_PALETTE  = 1'b0;
  localparam logic CMD_ROW_BYTE = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_PIXEL_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE = 2'd2;

  localparam logic [COL_W-1:0] RESET_ROW_WIDTH  = 13'd1;
  localparam logic [POS_W-1:0] RESET_ROW_STRIDE = 14'd4;

  localparam logic [CNT_W-1:0] PIX_PER_BYTE_1BPP = 4'd8;
  localparam logic [CNT_W-1:0] PIX_PER_BYTE_4BPP = 4'd2;
  localparam logic [SUB_W-1:0] MSB_SLOT          = 3'd7;

endpackage

FILE: rtl/bitmap_row_palette_expander.sv
// bitmap_row_palette_expander: unpacks stored bitmap row bytes into rgb pixels
// depends on bpx_pkg; checked by bpx_checker
//
// Each request is a palette write or one raw row byte. Palette writes and bytes
// that give no pixel (padding, columns past the row width, the first two bytes
// of a 24-bpp pixel) are taken at one request per cycle while no earlier byte
// has pixels left. A byte that gives n pixels (up to 8 in 1-bpp mode, 2 in 4-bpp,
// 1 otherwise) stalls the request side until its last pixel is issued, also while
// the pixel side stalls, as pixels leave one per cycle through the single palette
// read port. A taken byte is registered in the work stage before its pixels reach
// the output register, which lets the next request be taken while a pixel waits.
// Palette entries read before they are written return unspecified colours.
module bitmap_row_palette_expander import bpx_pkg::*; #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  command,
  input  logic [7:0]            palette_slot,
  input  logic [7:0]            palette_red,
  input  logic [7:0]            palette_green,
  input  logic [7:0]            palette_blue,
  input  logic [7:0]            data_byte,
  output logic                  pix_valid,
  input  logic                  pix_stall,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic                  row_end,
  output logic                  last
);

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  mode_t             pixel_mode;
  logic [COL_W-1:0]  row_width;
  logic [POS_W-1:0]  row_stride;

  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [COL_W-1:0]  pixel_column, pixel_column_next;
  logic [HELD_W-1:0] held_bytes, held_bytes_next;
  logic [1:0]        held_count, held_count_next;

  logic [COL_W-1:0]  eff_width, remain;
  logic [POS_W-1:0]  stride, pos_inc;
  logic              in_row, accept, issue;
  logic [CNT_W-1:0]  cnt;

  logic              w_vld;
  logic [7:0]        w_byte;
  mode_t             w_mode;
  logic [COL_W-1:0]  w_col, w_width;
  logic [CNT_W-1:0]  w_cnt;
  logic [SUB_W-1:0]  w_k;
  logic [23:0]       w_rgb;
  logic              w_last;
  logic [7:0]        idx;
  logic              idx_ok;

  logic [23:0]       palette_mem [PALETTE_DEPTH];
  logic [23:0]       pal_rd;

  logic              o_vld, o_direct, o_zero, o_row_end, o_last;
  logic [23:0]       o_rgb, o_color;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= MODE_8BPP;
      row_width  <= RESET_ROW_WIDTH;
      row_stride <= RESET_ROW_STRIDE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_MODE: pixel_mode <= mode_t'(cfg_data[1:0]);
        REG_ROW_WIDTH:  row_width  <= cfg_data[COL_W-1:0];
        REG_ROW_STRIDE: row_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_width = (32'(row_width) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : row_width;
  assign stride    = (row_stride == '0) ? POS_W'(1) : row_stride;
  assign in_row    = pixel_column < eff_width;
  assign remain    = eff_width - pixel_column;
  assign pos_inc   = byte_position + POS_W'(1);
  assign accept    = req_valid && !req_stall;

  // pixels given by the byte at the head of the request channel
  always_comb begin
    cnt = '0;
    if (in_row) begin
      unique case (pixel_mode)
        MODE_1BPP:
          cnt = (remain >= COL_W'(PIX_PER_BYTE_1BPP)) ? PIX_PER_BYTE_1BPP
                                                      : remain[CNT_W-1:0];
        MODE_4BPP:
          cnt = (remain >= COL_W'(PIX_PER_BYTE_4BPP)) ? PIX_PER_BYTE_4BPP
                                                      : CNT_W'(1);
        MODE_8BPP:
          cnt = CNT_W'(1);
        MODE_24BPP:
          cnt = (held_count >= 2'd2) ? CNT_W'(1) : '0;
        default: cnt = '0;
      endcase
    end
  end

  // row position and 24-bpp gathering
  always_comb begin
    byte_position_next = byte_position;
    pixel_column_next  = pixel_column;
    held_bytes_next    = held_bytes;
    held_count_next    = held_count;
    if (accept && command == CMD_ROW_BYTE) begin
      pixel_column_next = pixel_column + COL_W'(cnt);
      if (pixel_mode == MODE_24BPP && in_row) begin
        if (held_count >= 2'd2) begin
          held_bytes_next = '0;
          held_count_next = '0;
        end else begin
          if (held_count == 2'd0) begin
            held_bytes_next = held_bytes | {8'h00, data_byte};
          end else begin
            held_bytes_next = held_bytes | {data_byte, 8'h00};
          end
          held_count_next = held_count + 2'd1;
        end
      end
      byte_position_next = pos_inc;
      if (pos_inc >= stride || pos_inc == '0) begin
        byte_position_next = '0;
        pixel_column_next  = '0;
        held_bytes_next    = '0;
        held_count_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pixel_column  <= '0;
      held_bytes    <= '0;
      held_count    <= '0;
    end else begin
      byte_position <= byte_position_next;
      pixel_column  <= pixel_column_next;
      held_bytes    <= held_bytes_next;
      held_count    <= held_count_next;
    end
  end

  // work stage: one pixel lookup per cycle unless the pixel side stalls
  assign w_last    = ({1'b0, w_k} == w_cnt - CNT_W'(1));
  assign issue     = w_vld && (!o_vld || !pix_stall);
  assign req_stall = w_vld && !(issue && w_last);

  always_comb begin
    unique case (w_mode)
      MODE_1BPP: idx = {7'b0, w_byte[MSB_SLOT - w_k]};
      MODE_4BPP: idx = (w_k == '0) ? {4'b0, w_byte[7:4]} : {4'b0, w_byte[3:0]};
      default:   idx = w_byte;
    endcase
  end

  assign idx_ok = 32'(idx) < PALETTE_DEPTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld <= 1'b0;
    end else if (accept) begin
      w_vld <= (command == CMD_ROW_BYTE) && (cnt != '0);
    end else if (issue && w_last) begin
      w_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_byte  <= data_byte;
      w_mode  <= pixel_mode;
      w_col   <= pixel_column;
      w_width <= eff_width;
      w_cnt   <= cnt;
      w_k     <= '0;
      w_rgb   <= {data_byte, held_bytes[15:8], held_bytes[7:0]};
    end else if (issue) begin
      w_k   <= w_k + SUB_W'(1);
      w_col <= w_col + COL_W'(1);
    end
  end

  // palette memory, read data registered
  always_ff @(posedge clk) begin
    if (accept && command == CMD_PALETTE && 32'(palette_slot) < PALETTE_DEPTH) begin
      palette_mem[palette_slot[PAL_AW-1:0]] <= {palette_red, palette_green, palette_blue};
    end
    if (issue) begin
      pal_rd <= palette_mem[idx[PAL_AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (issue) begin
      o_vld <= 1'b1;
    end else if (!pix_stall) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      o_direct  <= (w_mode == MODE_24BPP);
      o_zero    <= !idx_ok;
      o_rgb     <= w_rgb;
      o_row_end <= ({1'b0, w_col} + 14'd1) == {1'b0, w_width};
      o_last    <= w_last;
    end
  end

  assign o_color   = o_direct ? o_rgb : (o_zero ? 24'h000000 : pal_rd);
  assign pix_valid = o_vld;
  assign red       = o_color[23:16];
  assign green     = o_color[15:8];
  assign blue      = o_color[7:0];
  assign row_end   = o_row_end;
  assign last      = o_last;

endmodule

FILE: rtl/bpx_checker.sv
// bpx_checker: port-level assertions for the bitmap row palette expander
// depends on bpx_pkg; bound to bitmap_row_palette_expander below
module bpx_checker import bpx_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       pix_valid,
  input logic       pix_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       row_end,
  input logic       last
);

  // output register empties on reset
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !pix_valid)
    else $error("pixel valid right after reset");

  // a stalled pixel holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(row_end) && $stable(last))
    else $error("stalled pixel changed");

  // remaining pixels of a byte follow without a gap
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall && !last |=> pix_valid)
    else $error("gap inside the pixels of one byte");

  // a request is never held back while the whole pipe is idle
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> $past(req_valid) || $past(req_stall))
    else $error("request stalled with no earlier request");

endmodule

bind bitmap_row_palette_expander bpx_checker u_bpx_checker (.*);
